// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the top-level rtl file of the heap block
// no dependencies; define ASSERT_OFF to drop all assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/rdmh_pkg.sv =====
// shared types and codes of the ready-delivery min-heap
// no dependencies
package rdmh_pkg;

    localparam int TIME_W = 64;
    localparam int SEQ_W  = 64;
    localparam int TAG_W  = 16;
    localparam int OCC_W  = 11;
    localparam int KEY_W  = TIME_W + SEQ_W;

    typedef struct packed {
        logic [TIME_W-1:0] key_time;
        logic [SEQ_W-1:0]  key_seq;
        logic [TAG_W-1:0]  entry_tag;
    } t_entry;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

// ===== rtl/core/rdmh_mem.sv =====
// heap slot memory: one write port, two read ports, registered read data
// depends on rdmh_pkg for the entry type
module rdmh_mem import rdmh_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output t_entry        o_rd_data_a,
    output t_entry        o_rd_data_b
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/core/ready_delivery_min_heap_top.sv =====
// Ready-delivery min-heap, top level: command sequencer, sift walk, result register.
// One item at a time; clear, no-op and refused commands go from the start state straight to
// the done state. Push and pop walk the heap one level per step (registered memory read,
// then compare and write back) until the item settles.
// Reset is synchronous active low: the queue is empty, slot contents are not cleared.
// depends on rdmh_pkg, rdmh_mem and assert_macros.svh
`include "assert_macros.svh"

module ready_delivery_min_heap_top import rdmh_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic [TIME_W-1:0] i_key_time,
    input  logic [SEQ_W-1:0]  i_key_seq,
    input  logic [TAG_W-1:0]  i_entry_tag,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [TIME_W-1:0] o_popped_time,
    output logic [SEQ_W-1:0]  o_popped_seq,
    output logic [TAG_W-1:0]  o_popped_tag,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = AW + 2;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_PUSH_UP  = 3'd2;
    localparam logic [2:0] S_PUSH_CMP = 3'd3;
    localparam logic [2:0] S_POP_LD   = 3'd4;
    localparam logic [2:0] S_SIFT_RD  = 3'd5;
    localparam logic [2:0] S_SIFT_CMP = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic [1:0]        r_cmd, n_cmd;
    t_entry            r_item, n_item;
    logic [1:0]        r_res_status, n_res_status;
    t_entry            r_res_pop, n_res_pop;
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_ostatus, n_ostatus;
    t_entry            r_opop, n_opop;
    logic [OCC_W-1:0]  r_oocc, n_oocc;

    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    t_entry            w_wr_data;
    logic [AW-1:0]     w_rd_a;
    logic [AW-1:0]     w_rd_b;
    t_entry            w_dat_a;
    t_entry            w_dat_b;

    logic [AW-1:0]     w_parent;
    logic [LW-1:0]     w_left;
    logic [LW-1:0]     w_right;
    logic              w_left_ok;
    logic              w_right_ok;
    logic              w_push_less;
    logic              w_left_take;
    logic              w_right_take;
    logic              w_out_free;

    function automatic logic key_less(t_entry a, t_entry b);
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        ka = {a.key_time, a.key_seq};
        kb = {b.key_time, b.key_seq};
        return ka < kb;
    endfunction

    rdmh_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_rd_a),
        .i_rd_addr_b (w_rd_b),
        .o_rd_data_a (w_dat_a),
        .o_rd_data_b (w_dat_b)
    );

    assign w_parent     = (r_idx - AW'(1)) >> 1;
    assign w_left       = {1'b0, r_idx, 1'b1};
    assign w_right      = w_left + LW'(1);
    assign w_left_ok    = w_left < LW'(r_count);
    assign w_right_ok   = w_right < LW'(r_count);
    assign w_push_less  = key_less(r_item, w_dat_a);
    assign w_left_take  = w_left_ok && key_less(w_dat_a, r_item);
    assign w_right_take = w_right_ok && (w_left_take ? key_less(w_dat_b, w_dat_a)
                                                     : key_less(w_dat_b, r_item));
    assign w_out_free   = !r_ovalid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_cmd        = r_cmd;
        n_item       = r_item;
        n_res_status = r_res_status;
        n_res_pop    = r_res_pop;
        n_ovalid     = r_ovalid;
        n_ostatus    = r_ostatus;
        n_opop       = r_opop;
        n_oocc       = r_oocc;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_data    = r_item;
        w_rd_a       = '0;
        w_rd_b       = '0;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_command;
                    n_item  = '{key_time: i_key_time, key_seq: i_key_seq,
                                entry_tag: i_entry_tag};
                    n_state = S_START;
                end
            end
            S_START: begin
                n_res_status = ST_OK;
                n_res_pop    = '0;
                n_state      = S_DONE;
                case (r_cmd)
                    CMD_PUSH: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            n_idx   = AW'(r_count);
                            n_count = r_count + CW'(1);
                            n_state = S_PUSH_UP;
                        end
                    end
                    CMD_POP: begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            w_rd_a  = '0;
                            w_rd_b  = AW'(r_count - CW'(1));
                            n_count = r_count - CW'(1);
                            n_state = S_POP_LD;
                        end
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_PUSH_UP: begin
                if (r_idx == '0) begin
                    w_wr_en = 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_rd_a  = w_parent;
                    n_state = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                w_wr_en = 1'b1;
                if (w_push_less) begin
                    w_wr_data = w_dat_a;
                    n_idx     = w_parent;
                    n_state   = S_PUSH_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP_LD: begin
                n_res_pop = w_dat_a;
                n_item    = w_dat_b;
                n_idx     = '0;
                n_state   = (r_count == '0) ? S_DONE : S_SIFT_RD;
            end
            S_SIFT_RD: begin
                w_rd_a  = w_left[AW-1:0];
                w_rd_b  = w_right[AW-1:0];
                n_state = S_SIFT_CMP;
            end
            S_SIFT_CMP: begin
                w_wr_en = 1'b1;
                if (w_right_take) begin
                    w_wr_data = w_dat_b;
                    n_idx     = w_right[AW-1:0];
                    n_state   = S_SIFT_RD;
                end else if (w_left_take) begin
                    w_wr_data = w_dat_a;
                    n_idx     = w_left[AW-1:0];
                    n_state   = S_SIFT_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res_status;
                    n_opop    = r_res_pop;
                    n_oocc    = OCC_W'(r_count);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cmd        <= n_cmd;
        r_item       <= n_item;
        r_res_status <= n_res_status;
        r_res_pop    <= n_res_pop;
        r_ostatus    <= n_ostatus;
        r_opop       <= n_opop;
        r_oocc       <= n_oocc;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_popped_time = r_opop.key_time;
    assign o_popped_seq  = r_opop.key_seq;
    assign o_popped_tag  = r_opop.entry_tag;
    assign o_occupancy   = r_oocc;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `ASSERT_IMPLY(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !w_wr_en, "write while idle")
    `ASSERT_IMPLY(a_full_occ, i_clk, i_rst_n, o_valid && o_status == ST_FULL, o_occupancy == OCC_W'(DEPTH), "refused push with queue not full")
    `ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, o_valid && o_status == ST_EMPTY, o_occupancy == '0 && o_popped_tag == '0, "empty pop with data")

endmodule
